>>> src/dbst_pkg.sv
// ----------------------------------------------------------------------------
// dbst_pkg
// Shared types and codes for the breakpoint slot table.
// ----------------------------------------------------------------------------
package dbst_pkg;

  localparam int ADDR_W = 64;
  localparam int LEN_W  = 64;
  localparam int RTYPE_W = 8;

  // input tdata packing, lowest bit first
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 80;

  localparam logic [1:0] OP_REMOVE = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_NO_TARGET  = 3'd1;
  localparam logic [2:0] STATUS_EXITING    = 3'd2;
  localparam logic [2:0] STATUS_BAD_TYPE   = 3'd3;
  localparam logic [2:0] STATUS_BAD_LENGTH = 3'd4;

  localparam logic [RTYPE_W-1:0] MAX_RAW_TYPE = 8'd4;

  localparam logic [1:0] KIND_EXEC = 2'd0;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;
  localparam logic [1:0] SIZE_QWORD = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        kind;
    logic [1:0]        size;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic mark;
    logic write;
    logic shift;
  } cell_ctl_t;

endpackage

>>> src/dbst_decode.sv
// ----------------------------------------------------------------------------
// dbst_decode
// Checks an add or remove command and forms the entry it refers to.
// ----------------------------------------------------------------------------
module dbst_decode
  import dbst_pkg::*;
(
  input  logic [RTYPE_W-1:0] raw_type,
  input  logic [ADDR_W-1:0]  bp_address,
  input  logic [LEN_W-1:0]   bp_length,
  input  logic               target_present,
  input  logic               target_exiting,
  output logic [2:0]         status,
  output entry_t             entry
);

  logic [1:0] size_raw;
  logic       len_ok;
  logic [1:0] kind;

  always_comb begin
    len_ok   = 1'b1;
    size_raw = SIZE_BYTE;
    if (bp_length == LEN_W'(0) || bp_length == LEN_W'(1)) begin
      size_raw = SIZE_BYTE;
    end else if (bp_length == LEN_W'(2)) begin
      size_raw = SIZE_WORD;
    end else if (bp_length == LEN_W'(4)) begin
      size_raw = SIZE_DWORD;
    end else if (bp_length == LEN_W'(8)) begin
      size_raw = SIZE_QWORD;
    end else begin
      len_ok = 1'b0;
    end
  end

  // software type folds into hardware execute
  assign kind = (raw_type == '0) ? KIND_EXEC : 2'(raw_type - RTYPE_W'(1));

  always_comb begin
    if (!target_present) begin
      status = STATUS_NO_TARGET;
    end else if (target_exiting) begin
      status = STATUS_EXITING;
    end else if (raw_type > MAX_RAW_TYPE) begin
      status = STATUS_BAD_TYPE;
    end else if (!len_ok) begin
      status = STATUS_BAD_LENGTH;
    end else begin
      status = STATUS_OK;
    end
  end

  assign entry.addr = bp_address;
  assign entry.kind = kind;
  assign entry.size = (kind == KIND_EXEC) ? SIZE_BYTE : size_raw;

endmodule

>>> src/dbst_cell.sv
// ----------------------------------------------------------------------------
// dbst_cell
// One breakpoint slot: holds an entry and a delete mark, takes its right
// neighbor's contents when shifted.
// ----------------------------------------------------------------------------
module dbst_cell
  import dbst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    right_entry,
  input  logic      right_dead,
  output entry_t    entry,
  output logic      dead,
  output logic      empty
);

  logic hit;

  assign hit   = (entry == new_entry);
  assign empty = (entry.addr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
      dead  <= 1'b0;
    end else if (ctl.clear) begin
      entry <= '0;
      dead  <= 1'b0;
    end else if (ctl.mark) begin
      dead <= hit;
    end else if (ctl.write) begin
      entry <= new_entry;
    end else if (ctl.shift) begin
      entry <= right_entry;
      dead  <= right_dead;
    end
  end

endmodule

>>> src/debug_breakpoint_slot_table.sv
// ----------------------------------------------------------------------------
// debug_breakpoint_slot_table
// Hardware breakpoint slot table built as a row of slot cells.
// ----------------------------------------------------------------------------
// add and clear: update the slot row, then SLOTS items, one per cycle while m_tready is high
// remove: a marking step, then compaction of the marked slots, then SLOTS items
// failed check: one error item in the cycle after the item is taken
// one command at a time; the slot row is rotated through slot 0 to stream out
// reset empties every slot and returns the controller to idle
// ----------------------------------------------------------------------------
module debug_breakpoint_slot_table
  import dbst_pkg::*;
#(
  parameter int SLOTS = 4
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // opcode[1:0], raw_type[9:2], bp_address[73:10], bp_length[137:74],
  // target_present[138], target_exiting[139], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status[2:0], slot_index[4:3], slot_address[68:5], slot_kind[70:69],
  // slot_size[72:71], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COMPACT = 4'b0010,
    ST_EMIT    = 4'b0100,
    ST_ERROR   = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [2:0]    err, err_next;

  logic [1:0]         opcode;
  logic [RTYPE_W-1:0] raw_type;
  logic [ADDR_W-1:0]  bp_address;
  logic [LEN_W-1:0]   bp_length;
  logic               target_present;
  logic               target_exiting;

  assign opcode         = s_tdata[1:0];
  assign raw_type       = s_tdata[9:2];
  assign bp_address     = s_tdata[73:10];
  assign bp_length      = s_tdata[137:74];
  assign target_present = s_tdata[138];
  assign target_exiting = s_tdata[139];

  logic [2:0] chk_status;
  entry_t     new_entry;

  dbst_decode u_decode (
    .raw_type       (raw_type),
    .bp_address     (bp_address),
    .bp_length      (bp_length),
    .target_present (target_present),
    .target_exiting (target_exiting),
    .status         (chk_status),
    .entry          (new_entry)
  );

  entry_t           cell_q [SLOTS];
  cell_ctl_t        ctl    [SLOTS];
  logic [SLOTS-1:0] dead;
  logic [SLOTS-1:0] empty;
  logic [SLOTS-1:0] dead_pre;
  logic [SLOTS-1:0] first_empty;
  logic             any_empty;
  entry_t           tail_entry;
  logic             s_take;
  logic             m_take;

  assign s_take = s_tvalid && s_tready;
  assign m_take = m_tvalid && m_tready;

  // prefix scans across the row
  always_comb begin
    logic seen_dead;
    logic seen_empty;
    seen_dead  = 1'b0;
    seen_empty = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      seen_dead      = seen_dead | dead[i];
      dead_pre[i]    = seen_dead;
      first_empty[i] = empty[i] & ~seen_empty;
      seen_empty     = seen_empty | empty[i];
    end
    any_empty = seen_empty;
  end

  // what enters the right end of the row
  always_comb begin
    if (state == ST_EMIT) begin
      tail_entry = cell_q[0];
    end else if (state == ST_COMPACT) begin
      tail_entry = '0;
    end else begin
      tail_entry = new_entry;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ctl[i] = '0;
    end
    unique case (state)
      ST_IDLE: begin
        if (s_take) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (opcode == OP_CLEAR) begin
              ctl[i].clear = 1'b1;
            end else if (chk_status == STATUS_OK && opcode == OP_ADD) begin
              // full table drops slot 0 and appends at the end
              ctl[i].write = any_empty & first_empty[i];
              ctl[i].shift = ~any_empty;
            end else if (chk_status == STATUS_OK && opcode == OP_REMOVE) begin
              ctl[i].mark = 1'b1;
            end
          end
        end
      end
      ST_COMPACT: begin
        // squeeze out the first marked slot each cycle
        for (int i = 0; i < SLOTS; i++) begin
          ctl[i].shift = dead_pre[i];
        end
      end
      ST_EMIT: begin
        for (int i = 0; i < SLOTS; i++) begin
          ctl[i].shift = m_tready;
        end
      end
      ST_ERROR: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    entry_t right_entry;
    if (g == SLOTS - 1) begin : g_tail
      assign right_entry = tail_entry;
    end else begin : g_mid
      assign right_entry = cell_q[g+1];
    end

    dbst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[g]),
      .new_entry   (new_entry),
      .right_entry (right_entry),
      .right_dead  ((g == SLOTS - 1) ? 1'b0 : dead[(g+1) % SLOTS]),
      .entry       (cell_q[g]),
      .dead        (dead[g]),
      .empty       (empty[g])
    );
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    err_next   = err;
    unique case (state)
      ST_IDLE: begin
        if (s_take) begin
          cnt_next = '0;
          if (opcode == OP_CLEAR) begin
            state_next = ST_EMIT;
          end else if (opcode == OP_ADD || opcode == OP_REMOVE) begin
            if (chk_status != STATUS_OK) begin
              err_next   = chk_status;
              state_next = ST_ERROR;
            end else if (opcode == OP_ADD) begin
              state_next = ST_EMIT;
            end else begin
              state_next = ST_COMPACT;
            end
          end
        end
      end
      ST_COMPACT: begin
        if (cnt == CNT_LAST) begin
          cnt_next   = '0;
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      ST_EMIT: begin
        if (m_tready) begin
          if (cnt == CNT_LAST) begin
            cnt_next   = '0;
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + CW'(1);
          end
        end
      end
      ST_ERROR: begin
        if (m_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      err   <= STATUS_OK;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      err   <= err_next;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT) || (state == ST_ERROR);

  always_comb begin
    m_tdata = '0;
    m_tlast = 1'b1;
    if (state == ST_EMIT) begin
      m_tdata[2:0]   = STATUS_OK;
      m_tdata[4:3]   = 2'(cnt);
      m_tdata[68:5]  = cell_q[0].addr;
      m_tdata[70:69] = cell_q[0].kind;
      m_tdata[72:71] = cell_q[0].size;
      m_tlast        = (cnt == CNT_LAST);
    end else begin
      m_tdata[2:0] = err;
    end
  end

endmodule
